// ===== sv/tcwf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tcwf_pkg;

	localparam int unsigned DeactPeriods = 100;
	localparam int unsigned AngleLimit = 1024;
	localparam int unsigned AngleShrinkQ16 = 32768;
	localparam bit ErrorScaledIncrease = 1'b1;

	localparam logic [16:0] OneQ16 = 17'd65536;
	localparam logic [16:0] ErrMinQ16 = 17'd6554;
	localparam logic [31:0] EpsScaled = 32'd1074;

	typedef enum logic [1:0] {
		MODE_INACTIVE = 2'd0,
		MODE_HOLD = 2'd1,
		MODE_REDUCE = 2'd2,
		MODE_INCREASE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_THR_HR = 3'd0,
		REG_THR_RH = 3'd1,
		REG_THR_HI = 3'd2,
		REG_THR_IH = 3'd3,
		REG_THR_SAFE = 3'd4,
		REG_RED_STEP = 3'd5,
		REG_INC_STEP = 3'd6,
		REG_INIT_RATIO = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESC_START,
		ST_RESC_WAIT,
		ST_ERR_START,
		ST_ERR_WAIT,
		ST_DECIDE,
		ST_MUL_STEP,
		ST_APPLY,
		ST_FOUT,
		ST_POUT,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic [47:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [47:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/tcwf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcwf_div
	import tcwf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);

	logic [47:0] quo_q;
	logic [47:0] num_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] rem_sh;
	logic [33:0] diff;

	always_comb begin
		rem_sh = {rem_q[31:0], num_q[47]};
		diff = {1'b0, rem_sh} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule
`default_nettype wire

// ===== sv/traction_control_wheel_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per-wheel traction control, one input transfer per control period.
// The input channel (in_valid, in_stall) carries slip, slip angle, drive
// force, baseline pressure, the allowed flag and the force-to-pressure
// factor. The output channel (out_valid, out_stall) returns one result per
// input: the limited force, the brake pressure, the mode and the active flag.
// Thresholds and steps are written through the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) while the block is idle.
// The force rescale and the slip error each use the shared 48-bit restoring
// divider when they need it, and the remaining steps run on one shared
// multiplier under the sequencer.
// One item is processed at a time; in_stall is high from acceptance until
// the result has been transferred out, so the next input transfer comes at
// best in the cycle after that.
// Reset clears the mode, the saved slip, force and fraction, sets the
// crossing counter to saturated and loads the register defaults.
// When the receiver stalls, the result holds and no new input is taken.
module traction_control_wheel_fsm
	import tcwf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [15:0] slip,
	input wire logic signed [15:0] lat_angle,
	input wire logic signed [19:0] drive_force,
	input wire logic [15:0] base_pressure,
	input wire logic allowed,
	input wire logic [15:0] pressure_per_newton,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [19:0] force_out,
	output logic [15:0] pressure_out,
	output logic [1:0] mode,
	output logic active,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [16:0] cfg_data
);

	seq_state_t st_q, st_d;
	logic [14:0] thr_hr_q, thr_rh_q, thr_hi_q, thr_ih_q, thr_safe_q;
	logic [15:0] red_step_q, inc_step_q;
	logic [16:0] init_ratio_q;

	mode_t mode_q;
	logic signed [15:0] prev_slip_q;
	logic [16:0] keep_q;
	logic signed [19:0] prev_force_q;
	logic [15:0] psc_q;

	logic signed [15:0] slip_q, angle_q;
	logic signed [19:0] force_q;
	logic [15:0] base_q, factor_q;
	logic allowed_q;
	logic signed [1:0] rate_q;
	logic [16:0] r_q;
	logic [16:0] err_q;
	logic [1:0] act_q;
	logic signed [20:0] fout_q;
	logic [15:0] pout_q;
	logic out_valid_q;
	logic deact_q;
	logic resc_neg_q;

	div_req_t dreq;
	div_rsp_t drsp;

	tcwf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	// Shared multiplier, 18 x 22 signed.
	logic signed [17:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [39:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic signed [32:0] s_w, t_hr, t_rh, t_hi, t_ih, t_sf;
	logic signed [33:0] d_raw;
	logic [32:0] d_abs;
	logic [31:0] den_w;
	logic [16:0] init_w;
	logic [16:0] a_w;

	always_comb begin
		s_w = 33'(slip_q) <<< 16;
		t_hr = $signed({1'b0, 32'(thr_hr_q) * 32'(r_q)});
		t_rh = $signed({1'b0, 32'(thr_rh_q) * 32'(r_q)});
		t_hi = $signed({1'b0, 32'(thr_hi_q) * 32'(r_q)});
		t_ih = $signed({1'b0, 32'(thr_ih_q) * 32'(r_q)});
		t_sf = $signed({1'b0, 32'(thr_safe_q) * 32'(r_q)});
		d_raw = 34'(t_hr) - 34'(s_w);
		d_abs = d_raw[33] ? 33'(-d_raw) : d_raw[32:0];
		den_w = (t_hr[31:0] > EpsScaled) ? t_hr[31:0] : EpsScaled;
		init_w = (init_ratio_q > OneQ16) ? OneQ16 : init_ratio_q;
		if (angle_q <= 0) a_w = '0;
		else if (angle_q >= 16'(AngleLimit)) a_w = OneQ16;
		else a_w = 17'((32'(angle_q) * 32'(OneQ16)) / AngleLimit);
	end

	// Rescale numerator and sign.
	logic signed [37:0] resc_num;
	logic resc_neg;
	logic [19:0] force_abs;
	always_comb begin
		resc_num = 38'(prev_force_q) * 38'($signed({1'b0, OneQ16 - keep_q}));
		resc_neg = resc_num[37] ^ force_q[19];
		force_abs = force_q[19] ? 20'(-force_q) : force_q;
	end

	mode_t m_next;
	always_comb begin
		m_next = mode_q;
		act_q = 2'd0;
		case (mode_q)
			MODE_INACTIVE: begin
				if (s_w >= t_hr && allowed_q && force_q > 0) m_next = MODE_HOLD;
			end
			MODE_HOLD: begin
				if (deact_q) m_next = MODE_INACTIVE;
				else if (s_w > t_hr && rate_q > 0) begin
					m_next = MODE_REDUCE; act_q = 2'd1;
				end else if (s_w <= t_hi && rate_q < 0) begin
					m_next = MODE_INCREASE; act_q = 2'd2;
				end
			end
			MODE_REDUCE: begin
				if (deact_q) m_next = MODE_INACTIVE;
				else if (s_w <= t_hi && rate_q < 0) begin
					m_next = MODE_INCREASE; act_q = 2'd2;
				end else if (rate_q < 0 || s_w < t_rh) m_next = MODE_HOLD;
				else act_q = 2'd1;
			end
			default: begin
				if (deact_q) m_next = MODE_INACTIVE;
				else if (s_w > t_hr && rate_q > 0) m_next = MODE_REDUCE;
				else if ((rate_q > 0 || s_w > t_ih) && s_w > t_sf) m_next = MODE_HOLD;
				else act_q = 2'd2;
			end
		endcase
	end

	logic [1:0] act_s1;
	logic signed [39:0] prod_q;

	logic m_next_inactive_or_neg;
	assign m_next_inactive_or_neg = (mode_q == MODE_INACTIVE) || force_q[19];

	always_comb begin
		st_d = st_q;
		dreq.start = 1'b0;
		dreq.num = '0;
		dreq.den = '0;
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_IDLE: if (in_valid) st_d = ST_RESC_START;
			ST_RESC_START: begin
				if (mode_q != MODE_INACTIVE && force_q != 0) begin
					dreq.start = 1'b1;
					dreq.num = {10'd0, (resc_num[37] ? 38'(-resc_num) : resc_num)};
					dreq.den = 32'(force_abs);
					st_d = ST_RESC_WAIT;
				end else st_d = ST_ERR_START;
			end
			ST_RESC_WAIT: if (drsp.done) st_d = ST_ERR_START;
			ST_ERR_START: begin
				if ({1'b0, d_abs} < {1'b0, den_w}) begin
					dreq.start = 1'b1;
					dreq.num = {d_abs[31:0], 16'd0};
					dreq.den = den_w;
					st_d = ST_ERR_WAIT;
				end else st_d = ST_DECIDE;
			end
			ST_ERR_WAIT: if (drsp.done) st_d = ST_DECIDE;
			ST_DECIDE: st_d = ST_MUL_STEP;
			ST_MUL_STEP: begin
				mul_a = $signed({1'b0, err_q});
				mul_b = (act_s1 == 2'd1) ? 22'($signed({1'b0, red_step_q}))
					: 22'($signed({1'b0, inc_step_q}));
				st_d = ST_APPLY;
			end
			ST_APPLY: st_d = ST_FOUT;
			ST_FOUT: begin
				mul_a = $signed({1'b0, keep_q});
				mul_b = 22'(force_q);
				st_d = ST_POUT;
			end
			ST_POUT: begin
				mul_a = $signed({2'b00, factor_q});
				mul_b = 22'(21'(force_q) - fout_q);
				st_d = ST_OUT;
			end
			ST_OUT: if (!out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			thr_hr_q <= 15'd1638;
			thr_rh_q <= 15'd1311;
			thr_hi_q <= 15'd819;
			thr_ih_q <= 15'd1147;
			thr_safe_q <= 15'd983;
			red_step_q <= 16'd3277;
			inc_step_q <= 16'd655;
			init_ratio_q <= 17'd49152;
			mode_q <= MODE_INACTIVE;
			prev_slip_q <= '0;
			keep_q <= '0;
			prev_force_q <= '0;
			psc_q <= 16'hFFFF;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_THR_HR: thr_hr_q <= cfg_data[14:0];
					REG_THR_RH: thr_rh_q <= cfg_data[14:0];
					REG_THR_HI: thr_hi_q <= cfg_data[14:0];
					REG_THR_IH: thr_ih_q <= cfg_data[14:0];
					REG_THR_SAFE: thr_safe_q <= cfg_data[14:0];
					REG_RED_STEP: red_step_q <= cfg_data[15:0];
					REG_INC_STEP: inc_step_q <= cfg_data[15:0];
					REG_INIT_RATIO: init_ratio_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_RESC_START: begin
					prev_slip_q <= slip_q;
					prev_force_q <= force_q;
					if (psc_q != 16'hFFFF) psc_q <= psc_q + 16'd1;
				end
				ST_RESC_WAIT: begin
					if (drsp.done) begin
						if (!resc_neg_q) begin
							keep_q <= (drsp.quo > 48'(OneQ16)) ? 17'd0
								: 17'(OneQ16 - 17'(drsp.quo));
						end else begin
							keep_q <= OneQ16;
						end
					end
				end
				ST_DECIDE: begin
					mode_q <= m_next;
					if (mode_q == MODE_INACTIVE && m_next == MODE_HOLD) keep_q <= init_w;
					if (mode_q == MODE_INCREASE && m_next == MODE_REDUCE
						&& keep_q > init_w) keep_q <= init_w;
				end
				ST_APPLY: begin
					if (act_s1 == 2'd1) begin
						keep_q <= (18'(keep_q) < 18'(prod_q[39:16])) ? 17'd0
							: 17'(keep_q - 17'(prod_q[39:16]));
					end else if (act_s1 == 2'd2) begin
						if (18'(keep_q) + 18'(ErrorScaledIncrease ? 17'(prod_q[39:16])
							: {1'b0, inc_step_q}) > 18'(OneQ16))
							keep_q <= OneQ16;
						else
							keep_q <= keep_q + (ErrorScaledIncrease ? 17'(prod_q[39:16])
								: {1'b0, inc_step_q});
					end
				end
				ST_POUT: begin
					if (s_w >= t_hr) psc_q <= '0;
				end
				default: ;
			endcase
			if (st_q == ST_POUT) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// Resc fraction when the quotient is negative means keep = 1 + |q|,
	// clamped to one.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					slip_q <= slip;
					angle_q <= lat_angle;
					force_q <= drive_force;
					base_q <= base_pressure;
					allowed_q <= allowed;
					factor_q <= pressure_per_newton;
				end
			end
			ST_RESC_START: begin
				resc_neg_q <= resc_neg;
				rate_q <= (slip_q > prev_slip_q) ? 2'sd1
					: ((slip_q < prev_slip_q) ? -2'sd1 : 2'sd0);
				r_q <= 17'(OneQ16 - 17'((34'(a_w) * 34'(AngleShrinkQ16)) >> 16));
				deact_q <= ((psc_q != 16'hFFFF ? 17'(psc_q) + 17'd1 : 17'(psc_q))
					> 17'(DeactPeriods)) || !allowed_q;
			end
			ST_ERR_START: begin
				if (!({1'b0, d_abs} < {1'b0, den_w})) err_q <= OneQ16;
			end
			ST_ERR_WAIT: begin
				if (drsp.done) err_q <= (17'(drsp.quo) < ErrMinQ16) ? ErrMinQ16
					: 17'(drsp.quo);
			end
			ST_DECIDE: begin
				act_s1 <= act_q;
				if (err_q < ErrMinQ16) err_q <= ErrMinQ16;
			end
			ST_MUL_STEP: prod_q <= mul_p;
			ST_FOUT: begin
				fout_q <= 21'((mul_p + (mul_p[39] ? 40'sd65535 : 40'sd0)) >>> 16);
			end
			ST_POUT: begin
				if (m_next_inactive_or_neg) begin
					fout_q <= 21'(force_q);
					pout_q <= base_q;
				end else if (fout_q <= 21'(force_q)) begin
					if (mul_p[39:16] > 24'd65535) pout_q <= 16'hFFFF;
					else pout_q <= (mul_p[31:16] < base_q) ? base_q : mul_p[31:16];
				end else pout_q <= base_q;
			end
			default: ;
		endcase
	end

	assign in_stall = (st_q != ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign force_out = fout_q[19:0];
	assign pressure_out = pout_q;
	assign mode = mode_q;
	assign active = (mode_q != MODE_INACTIVE);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import tcwf_pkg::*;

	typedef struct {
		logic signed [15:0] slip;
		logic signed [15:0] angle;
		logic signed [19:0] force_req;
		logic [15:0] base;
		logic allow;
		logic [15:0] factor;
	} period_t;

	typedef struct {
		logic signed [19:0] force_lim;
		logic [15:0] pressure;
		mode_t md;
		logic act;
	} wheel_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] slip = '0;
	logic signed [15:0] lat_angle = '0;
	logic signed [19:0] drive_force = '0;
	logic [15:0] base_pressure = '0;
	logic allowed = 1'b0;
	logic [15:0] pressure_per_newton = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [19:0] force_out;
	logic [15:0] pressure_out;
	logic [1:0] mode;
	logic active;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	traction_control_wheel_fsm dut (.*);

	always #5 clk = ~clk;

	period_t pending_q[$];
	wheel_cmd_t cmd_q[$];
	period_t cur;
	int errors = 0;
	int sent = 0;
	int received = 0;
	int gap = 0;
	int stall_cnt = 0;
	int hold_cnt = 0;
	bit hold_done = 0;
	bit quiet = 0;
	int mode_hits[4] = '{0, 0, 0, 0};

	// Shadow of the wheel controller.
	longint thr[5];
	longint red_step, inc_step, init_ratio;
	mode_t w_mode;
	longint w_prev_slip, w_keep, w_prev_force;
	int unsigned w_cross;

	function automatic longint clamp_one(longint v);
		return v < 0 ? 0 : (v > 65536 ? 65536 : v);
	endfunction

	function automatic void set_reg(reg_idx_t idx, logic [16:0] val);
		case (idx)
			REG_RED_STEP: red_step = val[15:0];
			REG_INC_STEP: inc_step = val[15:0];
			REG_INIT_RATIO: init_ratio = val;
			default: thr[idx] = val[14:0];
		endcase
	endfunction

	function automatic void predict_period(period_t p);
		longint s_in, ang, f, init, a, r, s, t_hr, d, den, err, fo, po;
		int rate;
		bit deact;
		wheel_cmd_t c;
		s_in = p.slip;
		ang = p.angle;
		f = p.force_req;
		init = init_ratio > 65536 ? 65536 : init_ratio;
		rate = s_in > w_prev_slip ? 1 : (s_in < w_prev_slip ? -1 : 0);
		w_prev_slip = s_in;
		if (w_mode != MODE_INACTIVE && f != 0)
			w_keep = clamp_one(65536 - (w_prev_force * (65536 - w_keep)) / f);
		w_prev_force = f;
		if (w_cross < 65535) w_cross++;
		deact = (w_cross > DeactPeriods) || !p.allow;
		if (ang <= 0) a = 0;
		else if (ang >= AngleLimit) a = 65536;
		else a = (ang * 65536) / AngleLimit;
		r = 65536 - (a * AngleShrinkQ16) / 65536;
		s = s_in * 65536;
		t_hr = thr[REG_THR_HR] * r;
		d = t_hr - s;
		if (d < 0) d = -d;
		den = t_hr > EpsScaled ? t_hr : EpsScaled;
		err = d >= den ? 65536 : (d * 65536) / den;
		if (err < ErrMinQ16) err = ErrMinQ16;
		case (w_mode)
			MODE_INACTIVE: begin
				if (s >= t_hr && p.allow && f > 0) begin
					w_keep = init;
					w_mode = MODE_HOLD;
				end
			end
			MODE_HOLD: begin
				if (deact) w_mode = MODE_INACTIVE;
				else if (s > t_hr && rate > 0) begin
					w_keep = clamp_one(w_keep - (err * red_step) / 65536);
					w_mode = MODE_REDUCE;
				end else if (s <= thr[REG_THR_HI] * r && rate < 0) begin
					w_keep = clamp_one(w_keep + (ErrorScaledIncrease ?
						(err * inc_step) / 65536 : inc_step));
					w_mode = MODE_INCREASE;
				end
			end
			MODE_REDUCE: begin
				if (deact) w_mode = MODE_INACTIVE;
				else if (s <= thr[REG_THR_HI] * r && rate < 0) begin
					w_keep = clamp_one(w_keep + (ErrorScaledIncrease ?
						(err * inc_step) / 65536 : inc_step));
					w_mode = MODE_INCREASE;
				end else if (rate < 0 || s < thr[REG_THR_RH] * r) w_mode = MODE_HOLD;
				else w_keep = clamp_one(w_keep - (err * red_step) / 65536);
			end
			default: begin
				if (deact) w_mode = MODE_INACTIVE;
				else if (s > t_hr && rate > 0) begin
					if (w_keep > init) w_keep = init;
					w_mode = MODE_REDUCE;
				end else if ((rate > 0 || s > thr[REG_THR_IH] * r) &&
						s > thr[REG_THR_SAFE] * r)
					w_mode = MODE_HOLD;
				else
					w_keep = clamp_one(w_keep + (ErrorScaledIncrease ?
						(err * inc_step) / 65536 : inc_step));
			end
		endcase
		fo = (w_keep * f) / 65536;
		po = 0;
		if (fo <= f) begin
			po = (longint'(p.factor) * (f - fo)) / 65536;
			if (po > 65535) po = 65535;
		end
		if (po < p.base) po = p.base;
		if (w_mode == MODE_INACTIVE || f < 0) begin
			fo = f;
			po = p.base;
		end
		if (s >= t_hr) w_cross = 0;
		c.force_lim = fo[19:0];
		c.pressure = po[15:0];
		c.md = w_mode;
		c.act = w_mode != MODE_INACTIVE;
		mode_hits[w_mode]++;
		cmd_q.push_back(c);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_period(cur);
				sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur = pending_q.pop_front();
					slip <= cur.slip;
					lat_angle <= cur.angle;
					drive_force <= cur.force_req;
					base_pressure <= cur.base;
					allowed <= cur.allow;
					pressure_per_newton <= cur.factor;
					in_valid <= 1'b1;
					if (quiet || $urandom_range(0, 2) == 0) gap = 0;
					else if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 150);
					else gap = $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		wheel_cmd_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				received++;
				if (cmd_q.size() == 0) begin
					$display("%0t: result with nothing expected: force %0d", $time, force_out);
					errors++;
				end else begin
					e = cmd_q.pop_front();
					if (force_out !== e.force_lim) begin
						$display("%0t: force_out expected %0d actual %0d",
							$time, e.force_lim, force_out);
						errors++;
					end
					if (pressure_out !== e.pressure) begin
						$display("%0t: pressure_out expected %0d actual %0d",
							$time, e.pressure, pressure_out);
						errors++;
					end
					if (mode !== e.md) begin
						$display("%0t: mode expected %0d actual %0d", $time, e.md, mode);
						errors++;
					end
					if (active !== e.act) begin
						$display("%0t: active expected %0b actual %0b", $time, e.act, active);
						errors++;
					end
				end
			end
			// The long hold-off lets the sender back up against a full block.
			if (!hold_done && received == 200) begin
				hold_done = 1;
				hold_cnt = 600;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall_cnt = $urandom_range(0, 9) == 0 ?
						$urandom_range(20, 120) : $urandom_range(1, 3);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [16:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_reg(idx, val);
	endtask

	task automatic wait_idle();
		wait (pending_q.size() == 0 && !in_valid && cmd_q.size() == 0);
		repeat (150) @(posedge clk);
	endtask

	function automatic period_t noise_period();
		period_t p;
		p.slip = $urandom;
		p.angle = $urandom;
		p.force_req = $urandom;
		p.base = $urandom;
		p.allow = $urandom;
		p.factor = $urandom;
		return p;
	endfunction

	// One slip excursion: rise through the thresholds and fall back, with noise.
	task automatic add_episode();
		period_t p;
		int len, amp, pos;
		len = $urandom_range(8, 60);
		amp = $urandom_range(0, 9) == 0 ? $urandom_range(0, 32767) :
			$urandom_range(int'(thr[REG_THR_HR]) / 2, int'(thr[REG_THR_HR]) * 3 + 200);
		for (int k = 0; k < len; k++) begin
			pos = k < len / 2 ? k : len - k;
			p = noise_period();
			p.slip = 16'(longint'(amp) * 2 * pos / len + $urandom_range(0, 200) - 100);
			if ($urandom_range(0, 3) != 0) p.angle = $urandom_range(0, 1200);
			if ($urandom_range(0, 9) != 0) p.force_req = $urandom_range(1, 20000);
			else if ($urandom_range(0, 1) == 0) p.force_req = 0;
			p.allow = $urandom_range(0, 29) != 0;
			pending_q.push_back(p);
		end
		// Sometimes let the slip stay low long enough for the dropout count.
		if ($urandom_range(0, 5) == 0)
			repeat (105) begin
				p = noise_period();
				p.slip = $urandom_range(0, 100);
				p.angle = 0;
				p.force_req = $urandom_range(1, 20000);
				p.allow = 1'b1;
				pending_q.push_back(p);
			end
	endtask

	task automatic random_phase(int n);
		int target;
		target = sent + n;
		while (sent + pending_q.size() < target) begin
			if ($urandom_range(0, 4) == 0) pending_q.push_back(noise_period());
			else add_episode();
			wait (pending_q.size() < 20);
		end
		wait_idle();
	endtask

	task automatic directed_phase();
		period_t p;
		int fv[3] = '{524287, -524288, 0};
		for (int k = 0; k < 24; k++) begin
			p.slip = k % 4 == 0 ? 16'sh7FFF : (k % 4 == 1 ? 16'sh8000 : 16'(k * 300));
			p.angle = k % 3 == 0 ? 16'sh7FFF : (k % 3 == 1 ? 16'sh8000 : 16'sd512);
			p.force_req = k < 12 ? 20'(k * 40000 + 1) : fv[k % 3];
			p.base = k % 2 ? 16'hFFFF : 16'h0;
			p.allow = k != 7 && k != 19;
			p.factor = k % 2 ? 16'h0 : 16'hFFFF;
			pending_q.push_back(p);
		end
		wait_idle();
	endtask

	task automatic write_all(logic [14:0] t0, logic [14:0] t1, logic [14:0] t2,
			logic [14:0] t3, logic [14:0] t4, logic [15:0] rs, logic [15:0] is,
			logic [16:0] ir);
		write_reg(REG_THR_HR, t0);
		write_reg(REG_THR_RH, t1);
		write_reg(REG_THR_HI, t2);
		write_reg(REG_THR_IH, t3);
		write_reg(REG_THR_SAFE, t4);
		write_reg(REG_RED_STEP, rs);
		write_reg(REG_INC_STEP, is);
		write_reg(REG_INIT_RATIO, ir);
	endtask

	initial begin
		thr = '{1638, 1311, 819, 1147, 983};
		red_step = 3277;
		inc_step = 655;
		init_ratio = 49152;
		w_mode = MODE_INACTIVE;
		w_prev_slip = 0;
		w_keep = 0;
		w_prev_force = 0;
		w_cross = 65535;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		directed_phase();
		random_phase(400);
		write_all(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
		random_phase(250);
		quiet = 1;
		write_all(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'h0, 16'h0, 17'h0);
		random_phase(200);
		quiet = 0;
		write_all(15'd3000, 15'd2500, 15'd800, 15'd1500, 15'd1200, 16'd20000, 16'd3000,
			17'd65536);
		random_phase(300);
		write_all($urandom_range(500, 4000), $urandom_range(300, 3000),
			$urandom_range(0, 1500), $urandom_range(500, 2500), $urandom_range(300, 2000),
			$urandom, $urandom, $urandom_range(0, 70000));
		random_phase(350);
		if (cmd_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, cmd_q.size());
			errors++;
		end
		$display("Periods sent %0d, results checked %0d, over five register settings.",
			sent, received);
		$display("Modes seen: inactive %0d, hold %0d, reduce %0d, increase %0d.",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
